>>> rtl/core/izh_pkg.sv
// Shared types, constants and helpers for the Izhikevich neuron update block.
// No dependencies; izhikevich_neuron_update and the bench refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package izh_pkg;

   // Reset state of one neuron, signed Q16.16
   localparam logic signed [31:0] RESET_V     = -32'sd4259840;
   localparam logic signed [31:0] RESET_U     = -32'sd851968;
   localparam logic signed [31:0] SPIKE_LEVEL = 32'sd1966080;
   localparam logic signed [36:0] CONST_140   = 37'sd9175040;

   // Register reset values
   localparam logic signed [31:0] RST_RATE_A  = 32'sd1311;
   localparam logic signed [31:0] RST_GAIN_B  = 32'sd13107;
   localparam logic signed [31:0] RST_JUMP_D  = 32'sd524288;
   localparam logic signed [31:0] RST_BIAS    = 32'sd0;
   localparam logic [16:0]        RST_DT      = 17'd32768;
   localparam logic [15:0]        RST_RATE_K  = 16'd66;

   // Drive = floor(s * 16384 / 25) = 655 s + floor(9 s / 25), saturating.
   // Outside this window of s the drive saturates.
   localparam logic signed [34:0] DRIVE_HI     = 35'sd3276799;
   localparam logic signed [34:0] DRIVE_LO     = -35'sd3276800;
   localparam logic signed [27:0] DRIVE_OFFSET = 28'sd52428800;  // 25 * 2^21
   localparam logic signed [34:0] DRIVE_UNOFF  = 35'sd2097152;   // 2^21

   // Reciprocals of 25: ceil(2^31 / 25) and ceil(2^26 / 25)
   localparam logic [26:0] RECIP25_K31 = 27'd85899346;
   localparam logic [21:0] RECIP25_K26 = 22'd2684355;

   // Quotient of v*v/2^16 by 25 is clamped at 2^36 (result saturates anyway)
   localparam logic [45:0]        SQ_BIG_LEVEL = 46'd1717986918400; // 25 * 2^36
   localparam logic signed [38:0] SQ_BIG_Q     = 39'sd68719476736;  // 2^36

   typedef struct packed {
      logic signed [31:0] rate_a;
      logic signed [31:0] gain_b;
      logic signed [31:0] reset_c;
      logic signed [31:0] jump_d;
      logic signed [31:0] bias;
      logic [16:0]        dt;
      logic [15:0]        rate_k;
   } izh_cfg_type;

   typedef enum logic [2:0] {
      CSR_RATE_A  = 3'd0,
      CSR_GAIN_B  = 3'd1,
      CSR_RESET_C = 3'd2,
      CSR_JUMP_D  = 3'd3,
      CSR_BIAS    = 3'd4,
      CSR_DT      = 3'd5,
      CSR_RATE_K  = 3'd6
   } izh_csr_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic [15:0]        r;
   } izh_state_type;

   // Saturate to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] y;
      if (x > 64'sd2147483647) begin
         y = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         y = 32'sh80000000;
      end else begin
         y = x[31:0];
      end
      return y;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/izh_if.sv
// Request and response channel interfaces of the neuron update block.
// Standalone; used by izhikevich_neuron_update.
`timescale 1ns / 1ps
`default_nettype none

interface izh_req_if;
   logic               valid;
   logic               ready;
   logic [9:0]         neuron_index;
   logic signed [31:0] exc_current;
   logic signed [31:0] inh_current;

   modport source (output valid, neuron_index, exc_current, inh_current, input ready);
   modport sink   (input valid, neuron_index, exc_current, inh_current, output ready);
endinterface

interface izh_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  neuron_id;
   logic        spike;
   logic [15:0] rate_estimate;

   modport source (output valid, neuron_id, spike, rate_estimate, input ready);
   modport sink   (input valid, neuron_id, spike, rate_estimate, output ready);
endinterface

`default_nettype wire

>>> rtl/core/izhikevich_neuron_update.sv
// Izhikevich neuron update: one Euler step per request word, state in RAM.
// Throughput: one word per cycle while the response side accepts; a word is held
// while the same neuron is still among the 8 words in flight, set by the
// read-modify-write interlock on the state RAM.
// Reset: synchronous; afterwards a clearing pass writes the reset state into every RAM
// entry, one per cycle (min(NEURON_COUNT,1024) entries), with request ready held low.
`timescale 1ns / 1ps
`default_nettype none

module izhikevich_neuron_update #(
   parameter int unsigned NEURON_COUNT = 1024
) (
   input  wire logic       clock,
   input  wire logic       reset,
   izh_req_if.sink         req_bus,
   izh_rsp_if.source       rsp_bus,
   input  wire logic       csr_write_en,
   input  wire logic [2:0] csr_index,
   input  wire logic [31:0] csr_write_data
);

   localparam int unsigned DEPTH = (NEURON_COUNT > 1024) ? 1024 : NEURON_COUNT;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SW    = $bits(izh_pkg::izh_state_type);

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [22:0] sc;
      logic               hi;
      logic               lo;
      logic [26:0]        t;
   } s1_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic [15:0]        r;
      logic [63:0]        vv;
      logic signed [63:0] bvp;
      logic [53:0]        dp;
      logic signed [32:0] s655;
      logic               hi;
      logic               lo;
      logic signed [36:0] pre;
   } s2_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic [15:0]        r;
      logic signed [36:0] pre;
      logic signed [31:0] drive;
      logic signed [31:0] e;
      logic [41:0]        whp;
      logic [19:0]        wh;
      logic [20:0]        wl;
      logic               big;
   } s3_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic [15:0]        r;
      logic signed [63:0] dup;
      logic signed [37:0] acc;
      logic [15:0]        qh;
      logic [25:0]        t2;
      logic               big;
   } s4_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic [15:0]        r;
      logic signed [31:0] du;
      logic signed [37:0] acc;
      logic [15:0]        qh;
      logic [52:0]        t2p;
      logic               big;
   } s5_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] v;
      logic signed [31:0] u;
      logic [15:0]        r;
      logic signed [31:0] dv;
      logic signed [48:0] dudt;
   } s6_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] v;
      logic signed [31:0] u1;
      logic signed [48:0] dvdt;
      logic [15:0]        r_up;
      logic [15:0]        r_dn;
   } s7_type;

   typedef struct packed {
      logic [9:0]         idx;
      logic               inr;
      logic signed [31:0] vs;
      logic signed [31:0] u1;
      logic [15:0]        r_up;
      logic [15:0]        r_dn;
   } s8_type;

   izh_pkg::izh_cfg_type cfg_ff, cfg_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   s8_type s8_ff, s8_in;
   logic [8:1] vld_ff, vld_in;

   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic        out_valid_ff, out_valid_in;
   logic [9:0]  out_id_ff, out_id_in;
   logic        out_spike_ff, out_spike_in;
   logic [15:0] out_rate_ff, out_rate_in;

   logic adv, hazard, accept;

   izh_pkg::izh_state_type rd_state, wr_state;
   logic          wr_en;
   logic [AW-1:0] wr_addr;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (izh_pkg::izh_csr_type'(csr_index))
            izh_pkg::CSR_RATE_A:  cfg_in.rate_a  = csr_write_data;
            izh_pkg::CSR_GAIN_B:  cfg_in.gain_b  = csr_write_data;
            izh_pkg::CSR_RESET_C: cfg_in.reset_c = csr_write_data;
            izh_pkg::CSR_JUMP_D:  cfg_in.jump_d  = csr_write_data;
            izh_pkg::CSR_BIAS:    cfg_in.bias    = csr_write_data;
            izh_pkg::CSR_DT:      cfg_in.dt      = csr_write_data[16:0];
            izh_pkg::CSR_RATE_K:  cfg_in.rate_k  = csr_write_data[15:0];
            default:              cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_a  <= izh_pkg::RST_RATE_A;
         cfg_ff.gain_b  <= izh_pkg::RST_GAIN_B;
         cfg_ff.reset_c <= izh_pkg::RESET_V;
         cfg_ff.jump_d  <= izh_pkg::RST_JUMP_D;
         cfg_ff.bias    <= izh_pkg::RST_BIAS;
         cfg_ff.dt      <= izh_pkg::RST_DT;
         cfg_ff.rate_k  <= izh_pkg::RST_RATE_K;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Clearing pass over the state RAM after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Handshake: advance when the output register is free; hold on same-neuron hazard
   assign adv = !out_valid_ff || rsp_bus.ready;
   assign hazard =
      (vld_ff[1] && s1_ff.idx == req_bus.neuron_index) ||
      (vld_ff[2] && s2_ff.idx == req_bus.neuron_index) ||
      (vld_ff[3] && s3_ff.idx == req_bus.neuron_index) ||
      (vld_ff[4] && s4_ff.idx == req_bus.neuron_index) ||
      (vld_ff[5] && s5_ff.idx == req_bus.neuron_index) ||
      (vld_ff[6] && s6_ff.idx == req_bus.neuron_index) ||
      (vld_ff[7] && s7_ff.idx == req_bus.neuron_index) ||
      (vld_ff[8] && s8_ff.idx == req_bus.neuron_index);
   assign req_bus.ready = adv && !clr_busy_ff && !hazard;
   assign accept = req_bus.valid && req_bus.ready;
   assign vld_in = {vld_ff[7:1], accept};

   // Stage 0: narrow the synaptic sum and flag saturation, offset 9s for the divide by 25
   logic signed [34:0] s_sum;
   logic signed [22:0] sc0;
   logic signed [27:0] t0;
   assign s_sum = 35'(req_bus.exc_current) + (35'(req_bus.inh_current) <<< 2);
   assign sc0 = $signed(s_sum[22:0]);
   assign t0 = 28'(sc0) * 28'sd9 + izh_pkg::DRIVE_OFFSET;

   always_comb begin
      s1_in.idx = req_bus.neuron_index;
      s1_in.inr = 32'(req_bus.neuron_index) < NEURON_COUNT;
      s1_in.sc  = sc0;
      s1_in.hi  = s_sum > izh_pkg::DRIVE_HI;
      s1_in.lo  = s_sum < izh_pkg::DRIVE_LO;
      s1_in.t   = t0[26:0];
   end

   // Stage 1: state from RAM; square, b*v, drive products, linear terms
   logic signed [63:0] vv_s;
   assign vv_s = 64'(rd_state.v) * 64'(rd_state.v);

   always_comb begin
      s2_in.idx  = s1_ff.idx;
      s2_in.inr  = s1_ff.inr;
      s2_in.v    = rd_state.v;
      s2_in.u    = rd_state.u;
      s2_in.r    = rd_state.r;
      s2_in.vv   = vv_s;
      s2_in.bvp  = 64'(cfg_ff.gain_b) * 64'(rd_state.v);
      s2_in.dp   = 54'(s1_ff.t) * 54'(izh_pkg::RECIP25_K31);
      s2_in.s655 = 33'(s1_ff.sc) * 33'sd655;
      s2_in.hi   = s1_ff.hi;
      s2_in.lo   = s1_ff.lo;
      s2_in.pre  = 37'(rd_state.v) * 37'sd5 + izh_pkg::CONST_140
                   - 37'(rd_state.u) + 37'(cfg_ff.bias);
   end

   // Stage 2: finish drive, b*v - u, split v*v/2^16 for the divide by 25
   // (v = -2^31 squares to 2^62, so bit 62 of the square is kept)
   logic signed [33:0] dq2;
   logic signed [34:0] drive_sum;
   logic signed [31:0] bv2, drive2;
   logic [46:0]        w2;
   assign dq2 = $signed({11'd0, s2_ff.dp[53:31]});
   assign drive_sum = 35'(s2_ff.s655) + 35'(dq2) - izh_pkg::DRIVE_UNOFF;
   assign bv2 = izh_pkg::sat32(64'(s2_ff.bvp >>> 16));
   assign w2 = s2_ff.vv[62:16];

   always_comb begin
      if (s2_ff.hi) begin
         drive2 = 32'sh7fffffff;
      end else if (s2_ff.lo) begin
         drive2 = 32'sh80000000;
      end else begin
         drive2 = izh_pkg::sat32(64'(drive_sum));
      end
   end

   always_comb begin
      s3_in.idx   = s2_ff.idx;
      s3_in.inr   = s2_ff.inr;
      s3_in.v     = s2_ff.v;
      s3_in.u     = s2_ff.u;
      s3_in.r     = s2_ff.r;
      s3_in.pre   = s2_ff.pre;
      s3_in.drive = drive2;
      s3_in.e     = izh_pkg::sat32(64'(bv2) - 64'(s2_ff.u));
      s3_in.whp   = 42'(w2[40:21]) * 42'(izh_pkg::RECIP25_K26);
      s3_in.wh    = w2[40:21];
      s3_in.wl    = w2[20:0];
      s3_in.big   = w2 >= 47'(izh_pkg::SQ_BIG_LEVEL);
   end

   // Stage 3: a*e, sum of linear terms, high quotient digit and remainder
   logic [15:0] qh3;
   logic [19:0] rh3;
   assign qh3 = s3_ff.whp[41:26];
   assign rh3 = s3_ff.wh - 20'(qh3) * 20'd25;

   always_comb begin
      s4_in.idx = s3_ff.idx;
      s4_in.inr = s3_ff.inr;
      s4_in.v   = s3_ff.v;
      s4_in.u   = s3_ff.u;
      s4_in.r   = s3_ff.r;
      s4_in.dup = 64'(cfg_ff.rate_a) * 64'(s3_ff.e);
      s4_in.acc = 38'(s3_ff.pre) + 38'(s3_ff.drive);
      s4_in.qh  = qh3;
      s4_in.t2  = {rh3[4:0], s3_ff.wl};
      s4_in.big = s3_ff.big;
   end

   // Stage 4: du, low quotient product
   always_comb begin
      s5_in.idx = s4_ff.idx;
      s5_in.inr = s4_ff.inr;
      s5_in.v   = s4_ff.v;
      s5_in.u   = s4_ff.u;
      s5_in.r   = s4_ff.r;
      s5_in.du  = izh_pkg::sat32(64'(s4_ff.dup >>> 16));
      s5_in.acc = s4_ff.acc;
      s5_in.qh  = s4_ff.qh;
      s5_in.t2p = 53'(s4_ff.t2) * 53'(izh_pkg::RECIP25_K31);
      s5_in.big = s4_ff.big;
   end

   // Stage 5: dv, du*dt
   logic [21:0]        ql5;
   logic signed [38:0] q5;
   assign ql5 = s5_ff.t2p[52:31];
   assign q5 = s5_ff.big ? izh_pkg::SQ_BIG_Q
                         : $signed({2'd0, s5_ff.qh, 21'd0}) + $signed({17'd0, ql5});

   always_comb begin
      s6_in.idx  = s5_ff.idx;
      s6_in.inr  = s5_ff.inr;
      s6_in.v    = s5_ff.v;
      s6_in.u    = s5_ff.u;
      s6_in.r    = s5_ff.r;
      s6_in.dv   = izh_pkg::sat32(64'(q5) + 64'(s5_ff.acc));
      s6_in.dudt = 49'(s5_ff.du) * $signed(49'(cfg_ff.dt));
   end

   // Stage 6: dv*dt, new u, both rate updates
   logic [32:0] up_prod, dn_prod;
   assign up_prod = 33'(cfg_ff.rate_k) * (33'd65536 - 33'(s6_ff.r));
   assign dn_prod = 33'(cfg_ff.rate_k) * 33'(s6_ff.r);

   always_comb begin
      s7_in.idx  = s6_ff.idx;
      s7_in.inr  = s6_ff.inr;
      s7_in.v    = s6_ff.v;
      s7_in.u1   = izh_pkg::sat32(64'(s6_ff.u) + 64'(s6_ff.dudt >>> 16));
      s7_in.dvdt = 49'(s6_ff.dv) * $signed(49'(cfg_ff.dt));
      s7_in.r_up = s6_ff.r + up_prod[31:16];
      s7_in.r_dn = s6_ff.r - dn_prod[31:16];
   end

   // Stage 7: new v
   always_comb begin
      s8_in.idx  = s7_ff.idx;
      s8_in.inr  = s7_ff.inr;
      s8_in.vs   = izh_pkg::sat32(64'(s7_ff.v) + 64'(s7_ff.dvdt >>> 16));
      s8_in.u1   = s7_ff.u1;
      s8_in.r_up = s7_ff.r_up;
      s8_in.r_dn = s7_ff.r_dn;
   end

   // Stage 8: clamp, spike decision, write back, load output word
   logic signed [34:0] limit;
   logic signed [31:0] vc8;
   logic               spike8;
   assign limit = (35'(cfg_ff.reset_c) * 35'sd5) >>> 1;
   assign vc8 = (35'(s8_ff.vs) < limit) ? izh_pkg::sat32(64'(limit)) : s8_ff.vs;
   assign spike8 = vc8 >= izh_pkg::SPIKE_LEVEL;

   always_comb begin
      wr_state.v = spike8 ? cfg_ff.reset_c : vc8;
      wr_state.u = spike8 ? izh_pkg::sat32(64'(s8_ff.u1) + 64'(cfg_ff.jump_d)) : s8_ff.u1;
      wr_state.r = spike8 ? s8_ff.r_up : s8_ff.r_dn;
      out_valid_in = vld_ff[8];
      out_id_in    = s8_ff.idx;
      out_spike_in = s8_ff.inr && spike8;
      out_rate_in  = s8_ff.inr ? wr_state.r : 16'd0;
   end

   // Pipeline control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         s4_ff        <= s4_in;
         s5_ff        <= s5_in;
         s6_ff        <= s6_in;
         s7_ff        <= s7_in;
         s8_ff        <= s8_in;
         out_id_ff    <= out_id_in;
         out_spike_ff <= out_spike_in;
         out_rate_ff  <= out_rate_in;
      end
   end

   // State RAM: clearing pass or write back from the last stage
   izh_pkg::izh_state_type clr_state, ram_wdata;
   logic [SW-1:0] ram_rdata;
   always_comb begin
      clr_state.v = izh_pkg::RESET_V;
      clr_state.u = izh_pkg::RESET_U;
      clr_state.r = 16'd0;
      wr_en     = clr_busy_ff || (adv && vld_ff[8] && s8_ff.inr);
      wr_addr   = clr_busy_ff ? clr_addr_ff : s8_ff.idx[AW-1:0];
      ram_wdata = clr_busy_ff ? clr_state : wr_state;
   end
   assign rd_state = izh_pkg::izh_state_type'(ram_rdata);

   izh_state_ram #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .W     (SW)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (req_bus.neuron_index[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // Response word
   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.neuron_id     = out_id_ff;
   assign rsp_bus.spike         = out_spike_ff;
   assign rsp_bus.rate_estimate = out_rate_ff;

endmodule

`default_nettype wire

>>> rtl/core/izh_state_ram.sv
// Simple dual-port synchronous RAM holding per-neuron state.
// One write port, one read port with registered read data; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module izh_state_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned AW    = 10,
   parameter int unsigned W     = 80
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [W-1:0]  wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [W-1:0]       rd_data
);

   logic [W-1:0] mem [DEPTH];
   logic [W-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> bench/tb_izhikevich_neuron_update.sv
// Self-checking bench for izhikevich_neuron_update: random and directed neuron steps,
// checked word by word against an in-bench fixed-point Euler predictor.
// Depends on rtl/core/izh_pkg.sv, rtl/core/izh_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_izhikevich_neuron_update;

   localparam int  NEURONS       = 1024;
   localparam int  WATCHDOG_MAX  = 6000;   // clearing pass plus long receiver stalls
   localparam int  SETTLE_CYCLES = 20;     // margin past the pipeline latency
   localparam int  REPORT_MAX    = 10;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam longint SPIKE_Q16  = 1966080;
   localparam longint C140_Q16   = 9175040;

   typedef struct {
      logic [9:0]         idx;
      logic signed [31:0] exc;
      logic signed [31:0] inh;
   } step_word_type;

   typedef struct {
      logic [9:0]  id;
      logic        spike;
      logic [15:0] rate;
   } neuron_result_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   izh_req_if req_bus ();
   izh_rsp_if rsp_bus ();

   izhikevich_neuron_update dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus.sink),
      .rsp_bus        (rsp_bus.source),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   izh_pkg::izh_cfg_type cfg_now;
   int             pot_v  [NEURONS];
   int             rec_u  [NEURONS];
   logic [15:0]    rate_r [NEURONS];

   step_word_type     queued_steps [$];
   neuron_result_type due_results [$];

   int   fail_count;
   int   words_sent;
   int   words_checked;
   int   spikes_seen;
   int   settings_used;
   int   idle_cycles;
   int   burst_left;
   int   gap_left;
   int   stall_mode;
   int   stall_timer;
   logic drain_hold;
   logic drained_once;
   logic word_taken;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint clamp_i32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint div_floor(input longint x, input longint d);
      longint q;
      q = x / d;
      if ((x % d) != 0 && ((x < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   // One Euler step of the neuron; queues the result it should produce
   function automatic void euler_step(input step_word_type w);
      longint v, u, drive, dv, bv, e, du, limit;
      longint r, k;
      logic   fire;
      neuron_result_type res;
      res.id = w.idx;
      if (w.idx >= NEURONS) begin
         res.spike = 1'b0;
         res.rate  = 16'd0;
         due_results.push_back(res);
         return;
      end
      v = pot_v[w.idx];
      u = rec_u[w.idx];
      drive = clamp_i32(div_floor((longint'(w.exc) + 4 * longint'(w.inh)) * 65536, 100));
      dv = clamp_i32(div_floor(v * v, 25 * 65536) + 5 * v + C140_Q16 - u + drive
                     + longint'(cfg_now.bias));
      bv = clamp_i32(div_floor(longint'(cfg_now.gain_b) * v, 65536));
      e  = clamp_i32(bv - u);
      du = clamp_i32(div_floor(longint'(cfg_now.rate_a) * e, 65536));
      v = clamp_i32(v + div_floor(dv * longint'({1'b0, cfg_now.dt}), 65536));
      u = clamp_i32(u + div_floor(du * longint'({1'b0, cfg_now.dt}), 65536));
      limit = div_floor(longint'(cfg_now.reset_c) * 5, 2);
      if (v < limit) v = clamp_i32(limit);
      fire = (v >= SPIKE_Q16);
      r = rate_r[w.idx];
      k = cfg_now.rate_k;
      if (fire) begin
         u = clamp_i32(u + longint'(cfg_now.jump_d));
         v = cfg_now.reset_c;
         r = r + ((k * (65536 - r)) >>> 16);
      end else begin
         r = r - ((k * r) >>> 16);
      end
      pot_v[w.idx]  = int'(v);
      rec_u[w.idx]  = int'(u);
      rate_r[w.idx] = r[15:0];
      res.spike = fire;
      res.rate  = r[15:0];
      due_results.push_back(res);
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [31:0] data);
      case (idx)
         izh_pkg::CSR_RATE_A:  cfg_now.rate_a  = data;
         izh_pkg::CSR_GAIN_B:  cfg_now.gain_b  = data;
         izh_pkg::CSR_RESET_C: cfg_now.reset_c = data;
         izh_pkg::CSR_JUMP_D:  cfg_now.jump_d  = data;
         izh_pkg::CSR_BIAS:    cfg_now.bias    = data;
         izh_pkg::CSR_DT:      cfg_now.dt      = data[16:0];
         izh_pkg::CSR_RATE_K:  cfg_now.rate_k  = data[15:0];
         default: ;
      endcase
   endfunction

   task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      apply_register(idx, data);
   endtask

   // Write every register, then one write to the unmapped slot
   task automatic load_settings(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c, input logic [31:0] d,
                                input logic [31:0] bias, input logic [31:0] dt,
                                input logic [31:0] k);
      write_register(izh_pkg::CSR_RATE_A, a);
      write_register(izh_pkg::CSR_GAIN_B, b);
      write_register(izh_pkg::CSR_RESET_C, c);
      write_register(izh_pkg::CSR_JUMP_D, d);
      write_register(izh_pkg::CSR_BIAS, bias);
      write_register(izh_pkg::CSR_DT, dt);
      write_register(izh_pkg::CSR_RATE_K, k);
      write_register(CSR_UNUSED, $urandom);
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic queue_step(input logic [9:0] idx, input logic [31:0] exc,
                             input logic [31:0] inh);
      step_word_type w;
      w.idx = idx;
      w.exc = exc;
      w.inh = inh;
      queued_steps.push_back(w);
   endtask

   // Mostly a small pool of neurons with plausible currents, so potentials build
   // up and fire; the rest are full-range values and saturating extremes
   task automatic queue_random(input int count);
      logic [9:0]  idx;
      logic [31:0] exc;
      logic [31:0] inh;
      int          pick;
      for (int i = 0; i < count; i++) begin
         idx = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 15)) : 10'($urandom);
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            exc = $urandom_range(0, 3000);
            inh = -$urandom_range(0, 400);
         end else if (pick < 18) begin
            exc = $urandom;
            inh = $urandom;
         end else begin
            exc = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            inh = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         end
         queue_step(idx, exc, inh);
      end
   endtask

   // Let the queue empty and every result come back before touching registers
   task automatic drain_all();
      wait (queued_steps.size() == 0 && due_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of random length with random gaps and occasional full drains;
   // the first burst always ends in a full drain
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !word_taken) begin
         // hold the word until taken
      end else if (drain_hold) begin
         req_bus.valid <= 1'b0;
         if (due_results.size() == 0) begin
            drain_hold   = 1'b0;
            drained_once = 1'b1;
         end
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left--;
      end else if (queued_steps.size() != 0) begin
         req_bus.valid        <= 1'b1;
         req_bus.neuron_index <= queued_steps[0].idx;
         req_bus.exc_current  <= queued_steps[0].exc;
         req_bus.inh_current  <= queued_steps[0].inh;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            drain_hold = ($urandom_range(0, 24) == 0) || !drained_once;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Receiver: switch between always ready, light and heavy stalling
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_timer = $urandom_range(20, 200);
         stall_mode  = $urandom_range(0, 2);
      end
      stall_timer--;
      case (stall_mode)
         0:       rsp_bus.ready <= 1'b1;
         1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Predict on request accept, check on response accept, watch for hangs
   always @(posedge clock) begin
      neuron_result_type want;
      logic              moved;
      moved = 1'b0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         euler_step(queued_steps.pop_front());
         words_sent++;
         moved = 1'b1;
         word_taken <= 1'b1;
      end else begin
         word_taken <= 1'b0;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         moved = 1'b1;
         if (due_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("ERROR: unexpected word id=%0d spike=%0b rate=%0d",
                        rsp_bus.neuron_id, rsp_bus.spike, rsp_bus.rate_estimate);
         end else begin
            want = due_results.pop_front();
            words_checked++;
            if (rsp_bus.spike) spikes_seen++;
            if (rsp_bus.neuron_id !== want.id || rsp_bus.spike !== want.spike ||
                rsp_bus.rate_estimate !== want.rate) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("ERROR: word mismatch exp id=%0d spike=%0b rate=%0d, got id=%0d spike=%0b rate=%0d",
                           want.id, want.spike, want.rate, rsp_bus.neuron_id,
                           rsp_bus.spike, rsp_bus.rate_estimate);
            end
         end
      end
      if (moved || csr_write_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_MAX);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_index            = 3'd0;
      csr_write_data       = 32'd0;
      req_bus.valid        = 1'b0;
      req_bus.neuron_index = 10'd0;
      req_bus.exc_current  = 32'd0;
      req_bus.inh_current  = 32'd0;
      rsp_bus.ready        = 1'b0;
      fail_count    = 0;
      words_sent    = 0;
      words_checked = 0;
      spikes_seen   = 0;
      settings_used = 0;
      idle_cycles   = 0;
      burst_left    = 1;
      gap_left      = 0;
      stall_mode    = 0;
      stall_timer   = 0;
      drain_hold    = 1'b0;
      drained_once  = 1'b0;
      word_taken    = 1'b0;
      cfg_now.rate_a  = izh_pkg::RST_RATE_A;
      cfg_now.gain_b  = izh_pkg::RST_GAIN_B;
      cfg_now.reset_c = izh_pkg::RESET_V;
      cfg_now.jump_d  = izh_pkg::RST_JUMP_D;
      cfg_now.bias    = izh_pkg::RST_BIAS;
      cfg_now.dt      = izh_pkg::RST_DT;
      cfg_now.rate_k  = izh_pkg::RST_RATE_K;
      for (int i = 0; i < NEURONS; i++) begin
         pot_v[i]  = izh_pkg::RESET_V;
         rec_u[i]  = izh_pkg::RESET_U;
         rate_r[i] = 16'd0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, both ends of the index, then drive one neuron to fire
      queue_step(10'd0, 32'd0, 32'd0);
      queue_step(10'd1023, 32'h7fffffff, 32'h7fffffff);
      queue_step(10'd1022, 32'h80000000, 32'h80000000);
      queue_step(10'd1021, 32'h7fffffff, 32'h80000000);
      queue_step(10'd1020, 32'h80000000, 32'h7fffffff);
      queue_step(10'd512, 32'hffffffff, 32'h00000001);
      queue_step(10'd341, 32'h55555555, 32'haaaaaaaa);
      queue_step(10'd682, 32'haaaaaaaa, 32'h55555555);
      for (int i = 0; i < 8; i++) queue_step(10'd5, 32'd3000, 32'd0);
      for (int i = 0; i < 4; i++) queue_step(10'd6, 32'd0, -32'sd2000);
      queue_step(10'd1023, 32'd0, 32'd0);
      queue_random(250);
      drain_all();

      // all registers at one extreme, step above one via masked write
      load_settings(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                    32'h80000000, 32'hffffffff, 32'h0000ffff);
      queue_random(150);
      drain_all();

      // the other extreme, zero step and zero rate weight
      load_settings(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'd0, 32'd0);
      queue_random(150);
      drain_all();

      // fast-firing neuron with a constant bias, unit step
      load_settings(32'd1311, 32'd13107, -32'sd3276800, 32'd131072,
                    32'd655360, 32'd65536, 32'd2000);
      queue_random(300);
      drain_all();

      // every register fully random
      load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random(150);
      drain_all();

      // plausible parameters drawn at random
      for (int p = 0; p < 2; p++) begin
         load_settings($urandom_range(0, 10000), $urandom_range(0, 30000),
                       -$urandom_range(3276800, 4587520), $urandom_range(0, 1048576),
                       $urandom_range(0, 983040), $urandom_range(0, 65536),
                       $urandom_range(0, 65535));
         queue_random(300);
         drain_all();
      end

      $display("Ran %0d neuron steps over %0d register settings; %0d results checked",
               words_sent, settings_used, words_checked);
      $display("Results carried %0d spikes", spikes_seen);
      if (due_results.size() != 0) begin
         fail_count++;
         $display("ERROR: %0d results never arrived", due_results.size());
      end
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
